/* sv/hgdpf_pkg.sv */
// shared types and constants of the height grid dynamic point filter
package hgdpf_pkg;

  localparam int GRID_CELLS = 65536;
  localparam int IDX_W      = $clog2(GRID_CELLS);
  localparam int HIT_W      = 81;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_POINT = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_EOF   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CLS_NONE    = 3'd0,
    CLS_DISCARD = 3'd1,
    CLS_DART    = 3'd2,
    CLS_STATIC  = 3'd3,
    CLS_DYNAMIC = 3'd4
  } class_e;

  typedef enum logic [2:0] {
    CFG_X_ORIGIN = 3'd0,
    CFG_Y_ORIGIN = 3'd1,
    CFG_CELL     = 3'd2,
    CFG_COLS     = 3'd3,
    CFG_ROWS     = 3'd4,
    CFG_LIFE     = 3'd5,
    CFG_MARGIN   = 3'd6
  } cfg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_IDX,
    ST_HRD,
    ST_QRD,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* sv/hgdpf_div.sv */
// iterative restoring divider, one quotient bit per cycle
module hgdpf_div import hgdpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [9:0]  divisor_i,
  output logic [15:0] quotient_o,
  output div_stat_t   stat_o
);

  logic [15:0] quo_q;
  logic [9:0]  rem_q;
  logic [9:0]  dvs_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [10:0] sh;
  logic        fits;

  assign sh   = {rem_q, quo_q[15]};
  assign fits = sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[14:0], fits};
      rem_q <= fits ? 10'(sh - {1'b0, dvs_q}) : sh[9:0];
    end
  end

  assign quotient_o = quo_q;
  assign stat_o     = '{busy: busy_q, done: done_q};

endmodule

/* sv/height_grid_dynamic_point_filter_core.sv */
// top level of the height grid dynamic point filter
//
// channel   direction  handshake                 payload
// in        in         in_valid_i / in_ready_o   req_type_i .. now_ms_i
// out       out        out_valid_o / out_ready_i point_class_o .. ramp_flight_o
// cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one item at a time; a query reads the hit memory before its response,
// a point that reaches the grid runs the two cell dividers side by side,
// then multiply, index, height read
// after reset a clearing pass zeroes every entry of the hit memory;
// no item is taken meanwhile, config writes always are
// a finished result sits in the output register; a stalled output holds
// the block in its response state until the beat is taken
module height_grid_dynamic_point_filter_core import hgdpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] cell_index_i,
  input  logic signed [15:0] map_height_mm_i,
  input  logic        map_height_known_i,
  input  logic signed [15:0] point_x_mm_i,
  input  logic signed [15:0] point_y_mm_i,
  input  logic signed [15:0] point_z_mm_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  point_class_o,
  output logic [15:0] hit_cell_o,
  output logic        cell_active_o,
  output logic signed [15:0] hit_x_mm_o,
  output logic signed [15:0] hit_y_mm_o,
  output logic signed [15:0] hit_z_mm_o,
  output logic        dart_seen_o,
  output logic [1:0]  ramp_flight_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // configuration registers
  logic signed [15:0] xo_q, yo_q;
  logic [9:0]  cs_q;
  logic [15:0] cols_q, rows_q, life_q;
  logic [10:0] margin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xo_q     <= '0;
      yo_q     <= '0;
      cs_q     <= 10'd10;
      cols_q   <= 16'd256;
      rows_q   <= 16'd256;
      life_q   <= 16'd300;
      margin_q <= 11'd250;
    end else if (cfg_valid_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_X_ORIGIN: xo_q     <= cfg_data_i;
        CFG_Y_ORIGIN: yo_q     <= cfg_data_i;
        CFG_CELL:     cs_q     <= cfg_data_i[9:0];
        CFG_COLS:     cols_q   <= cfg_data_i;
        CFG_ROWS:     rows_q   <= cfg_data_i;
        CFG_LIFE:     life_q   <= cfg_data_i;
        CFG_MARGIN:   margin_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic   in_acc;
  logic   out_free;

  assign in_acc   = in_valid_i && in_ready_o;

  // point screening on the incoming beat
  logic pt_range_bad, pt_origin_bad, pt_dart, pt_to_grid;
  logic ramp_z, ramp_x, ramp_red, ramp_blue;
  logic [16:0] dx_full, dy_full;
  logic [9:0]  cs_eff;

  assign pt_range_bad  = point_z_mm_i < 16'sd30 || point_z_mm_i > 16'sd12000;
  assign pt_origin_bad = point_x_mm_i < xo_q || point_y_mm_i < yo_q;
  assign pt_dart       = point_z_mm_i > 16'sd3600 && point_z_mm_i < 16'sd12000;
  assign pt_to_grid    = !pt_range_bad && !pt_origin_bad && !pt_dart;
  assign ramp_z    = point_z_mm_i > 16'sd1500 && point_z_mm_i < 16'sd3000;
  assign ramp_x    = point_x_mm_i > 16'sd12500 && point_x_mm_i < 16'sd15500;
  assign ramp_red  = point_y_mm_i > 16'sd0 && point_y_mm_i < 16'sd2000;
  assign ramp_blue = point_y_mm_i > 16'sd13000 && point_y_mm_i < 16'sd15000;
  assign dx_full   = 17'({point_x_mm_i[15], point_x_mm_i} - {xo_q[15], xo_q});
  assign dy_full   = 17'({point_y_mm_i[15], point_y_mm_i} - {yo_q[15], yo_q});
  assign cs_eff    = (cs_q == '0) ? 10'd1 : cs_q;

  // cell dividers, x and y side by side
  logic        div_start;
  logic [15:0] cx, cy;
  div_stat_t   dstat_x, dstat_y;

  assign div_start = in_acc && req_e'(req_type_i) == REQ_POINT && pt_to_grid;

  hgdpf_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dx_full[15:0]),
    .divisor_i(cs_eff), .quotient_o(cx), .stat_o(dstat_x)
  );
  hgdpf_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dy_full[15:0]),
    .divisor_i(cs_eff), .quotient_o(cy), .stat_o(dstat_y)
  );

  // index arithmetic
  logic [31:0] prod_q;
  logic        inrange_q;
  logic [32:0] idx_sum;
  logic        idx_ok;

  assign idx_sum = {1'b0, prod_q} + {17'b0, cx};
  assign idx_ok  = inrange_q && idx_sum < 33'(GRID_CELLS);

  // latched point
  logic signed [15:0] px_q, py_q, pz_q;
  logic [31:0] now_q;
  logic [IDX_W-1:0] idx_q;

  // memories: static heights and hit records (valid, stamp, x, y, z)
  logic [16:0]       hmem [GRID_CELLS];
  logic [HIT_W-1:0]  tmem [GRID_CELLS];
  logic [16:0]       hrd_q;
  logic [HIT_W-1:0]  trd_q;
  logic              h_we, h_re, t_we, t_re;
  logic [IDX_W-1:0]  h_addr, t_addr;
  logic [16:0]       h_wdata;
  logic [HIT_W-1:0]  t_wdata;
  logic [IDX_W:0]    clr_q;

  always_ff @(posedge clk_i) begin
    if (h_we) hmem[h_addr] <= h_wdata;
    if (h_re) hrd_q <= hmem[h_addr];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) tmem[t_addr] <= t_wdata;
    if (t_re) trd_q <= tmem[t_addr];
  end

  // dynamic test against the height just read
  logic signed [15:0] h_s;
  logic signed [17:0] zdiff;
  logic signed [25:0] lhs;
  logic [19:0] rel;
  logic [17:0] absm;
  logic [19:0] thr;
  logic        dyn;

  assign h_s   = hrd_q[15:0];
  assign zdiff = 18'(pz_q) - 18'(h_s);
  assign lhs   = 26'(zdiff) * 26'sd100;
  assign rel   = (h_s > 16'sd0) ? {1'b0, h_s[15:0], 3'b000} : '0;
  assign absm  = 18'(margin_q * 18'd100);
  assign thr   = (rel > 20'(absm)) ? rel : 20'(absm);
  assign dyn   = hrd_q[16] ? (lhs > $signed({6'b0, thr})) : (pz_q >= 16'sd180);

  // query test
  logic [31:0] age;
  logic        q_active;
  logic        q_cell_ok_q;

  assign age      = now_q - trd_q[79:48];
  assign q_active = q_cell_ok_q && trd_q[80] && age < {16'b0, life_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == (IDX_W+1)'(GRID_CELLS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (req_e'(req_type_i))
            REQ_QUERY: state_d = ST_QRD;
            REQ_POINT: state_d = pt_to_grid ? ST_DIV : ST_RESP;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_DIV:  if (dstat_x.done && dstat_y.done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_IDX;
      ST_IDX:  state_d = idx_ok ? ST_HRD : ST_RESP;
      ST_HRD:  state_d = ST_RESP;
      ST_QRD:  state_d = ST_RESP;
      ST_RESP: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory strobes and handshake
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    h_we    = 1'b0;
    h_re    = 1'b0;
    t_we    = 1'b0;
    t_re    = 1'b0;
    h_addr  = IDX_W'(cell_index_i);
    t_addr  = IDX_W'(cell_index_i);
    h_wdata = {map_height_known_i, map_height_mm_i};
    t_wdata = {1'b1, now_q, px_q, py_q, pz_q};
    unique case (state_q)
      ST_CLEAR: begin
        t_we    = 1'b1;
        t_addr  = clr_q[IDX_W-1:0];
        t_wdata = '0;
      end
      ST_IDLE: begin
        h_we = in_acc && req_e'(req_type_i) == REQ_LOAD
               && 32'(cell_index_i) < 32'(GRID_CELLS);
        t_re = in_acc && req_e'(req_type_i) == REQ_QUERY;
      end
      ST_IDX: begin
        h_re   = idx_ok;
        h_addr = idx_sum[IDX_W-1:0];
      end
      ST_HRD: begin
        t_we   = dyn;
        t_addr = idx_q;
      end
      default: ;
    endcase
  end

  // result staging
  logic [2:0]  r_class_q;
  logic [15:0] r_cell_q;
  logic        r_act_q, r_dart_q;
  logic [1:0]  r_ramp_q;
  logic [47:0] r_pt_q;
  logic        dart_q;
  logic [1:0]  ramp_q;
  logic        out_valid_q;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      dart_q      <= 1'b0;
      ramp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + (IDX_W+1)'(1);
      if (in_acc && req_e'(req_type_i) == REQ_POINT
          && !pt_range_bad && !pt_origin_bad) begin
        if (pt_dart) dart_q <= 1'b1;
        else if (ramp_z && ramp_x) ramp_q <= ramp_q | {ramp_blue, ramp_red};
      end
      if (in_acc && req_e'(req_type_i) == REQ_EOF) begin
        dart_q <= 1'b0;
        ramp_q <= '0;
      end
      if (state_q == ST_RESP && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        px_q  <= point_x_mm_i;
        py_q  <= point_y_mm_i;
        pz_q  <= point_z_mm_i;
        now_q <= now_ms_i;
        q_cell_ok_q <= 32'(cell_index_i) < 32'(GRID_CELLS);
        r_class_q <= CLS_NONE;
        r_cell_q  <= '0;
        r_act_q   <= 1'b0;
        r_pt_q    <= '0;
        r_dart_q  <= 1'b0;
        r_ramp_q  <= '0;
        if (req_e'(req_type_i) == REQ_EOF) begin
          r_dart_q <= dart_q;
          r_ramp_q <= ramp_q;
        end
        if (req_e'(req_type_i) == REQ_POINT) begin
          if (pt_range_bad || pt_origin_bad) r_class_q <= CLS_DISCARD;
          else if (pt_dart) r_class_q <= CLS_DART;
        end
      end
      ST_MUL: begin
        prod_q    <= 32'(cy) * 32'(cols_q);
        inrange_q <= cx < cols_q && cy < rows_q;
      end
      ST_IDX: begin
        idx_q <= idx_sum[IDX_W-1:0];
        if (idx_ok) r_cell_q <= 16'(idx_sum[IDX_W-1:0]);
        else r_class_q <= CLS_DISCARD;
      end
      ST_HRD: r_class_q <= dyn ? CLS_DYNAMIC : CLS_STATIC;
      ST_QRD: begin
        r_act_q <= q_active;
        r_pt_q  <= q_active ? trd_q[47:0] : '0;
      end
      ST_RESP: begin
        if (out_free) begin
          point_class_o <= r_class_q;
          hit_cell_o    <= r_cell_q;
          cell_active_o <= r_act_q;
          hit_x_mm_o    <= r_pt_q[47:32];
          hit_y_mm_o    <= r_pt_q[31:16];
          hit_z_mm_o    <= r_pt_q[15:0];
          dart_seen_o   <= r_dart_q;
          ramp_flight_o <= r_ramp_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // no item enters while the hit memory is being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ready_o) else $error("item taken during clear");

  // a stamp write always reports a dynamic point
  a_dyn_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HRD && t_we) |=> r_class_q == CLS_DYNAMIC)
    else $error("stamp write without dynamic class");

  // an active cell only answers a query beat
  a_active_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cell_active_o) |-> point_class_o == CLS_NONE)
    else $error("active flag on a non-query result");

  // dividers run in lockstep
  a_div_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstat_x.busy == dstat_y.busy) else $error("dividers out of step");

endmodule
